@@ src/mtrk_pkg.sv @@
// shared types and constants for the multi-turn position tracker
package mtrk_pkg;

  localparam int PRECISION_BITS = 12;
  localparam int TURN_BITS      = 16;
  localparam int RAW_W          = 16;
  localparam int POS_W          = 28;
  localparam int VEL_W          = 32;
  localparam int ALPHA_W        = 16;
  localparam int CALC_W         = TURN_BITS + PRECISION_BITS + POS_W;
  localparam int PA_W           = POS_W + ALPHA_W + 1;
  localparam int PB_W           = VEL_W + ALPHA_W + 1;
  localparam int SUM_W          = PA_W + 8;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(46884);

  typedef enum logic [1:0] {
    FUNC_UPDATE   = 2'd0,
    FUNC_POSITION = 2'd1,
    FUNC_RESYNC   = 2'd2,
    FUNC_CLEAR    = 2'd3
  } func_e;

  typedef enum logic {
    REG_DIRECTION = 1'b0,
    REG_ALPHA     = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [RAW_W-1:0] raw_angle;
  } in_t;

  typedef struct packed {
    logic                    status;
    logic signed [POS_W-1:0] position_counts;
    logic signed [VEL_W-1:0] velocity_q16;
  } out_t;

  typedef struct packed {
    logic [PRECISION_BITS-1:0] last_raw;
    logic [TURN_BITS-1:0]      turn_count;
    logic [POS_W-1:0]          last_position;
    logic signed [VEL_W-1:0]   filtered_velocity;
  } st_t;

endpackage

@@ src/mtrk_update.sv @@
// next tracker state and result for one word: unwrap, position, iir velocity, resync or clear
module mtrk_update (
  input  mtrk_pkg::st_t              st_i,
  input  mtrk_pkg::in_t              item_i,
  input  logic                       dir_i,
  input  logic [mtrk_pkg::ALPHA_W-1:0] alpha_i,
  output mtrk_pkg::st_t              st_o,
  output mtrk_pkg::out_t             res_o
);

  localparam int PB = mtrk_pkg::PRECISION_BITS;
  localparam int TB = mtrk_pkg::TURN_BITS;
  localparam int CW = mtrk_pkg::CALC_W;
  localparam int SW = mtrk_pkg::SUM_W;
  localparam int VW = mtrk_pkg::VEL_W;

  localparam logic signed [PB:0] HalfPos = (PB+1)'(1 << (PB - 1));
  localparam logic signed [PB:0] HalfNeg = -HalfPos;
  localparam logic signed [SW-1:0] VelMax = (SW'(1) <<< (VW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] VelMin = -(SW'(1) <<< (VW - 1));

  logic                              bad;
  logic [PB-1:0]                     raw;
  logic signed [PB:0]                diff_raw;
  logic                              jump;
  logic                              up;
  logic [TB-1:0]                     turn_nx;
  logic signed [CW-1:0]              turn_ext;
  logic signed [CW-1:0]              raw_ext;
  logic signed [CW-1:0]              pos_full;
  logic [mtrk_pkg::POS_W-1:0]        pos_nx;
  logic signed [mtrk_pkg::POS_W-1:0] dp;
  logic signed [mtrk_pkg::ALPHA_W:0] alpha_s;
  logic signed [mtrk_pkg::PA_W-1:0]  prod_a;
  logic signed [mtrk_pkg::PB_W-1:0]  prod_b;
  logic signed [mtrk_pkg::PB_W:0]    neg_b;
  logic signed [mtrk_pkg::PB_W:0]    corr;
  logic signed [SW-1:0]              vel_sum;
  logic signed [VW-1:0]              vel_nx;

  always_comb begin
    bad      = |(item_i.raw_angle >> PB);
    raw      = item_i.raw_angle[PB-1:0];
    diff_raw = $signed({1'b0, st_i.last_raw}) - $signed({1'b0, raw});
    jump     = (diff_raw >= HalfPos) || (diff_raw <= HalfNeg);
    up       = !diff_raw[PB] ^ dir_i;
    if (jump) begin
      turn_nx = up ? st_i.turn_count + TB'(1) : st_i.turn_count - TB'(1);
    end else begin
      turn_nx = st_i.turn_count;
    end

    // position = turns * full scale + signed raw, wrapped to the position width
    turn_ext = $signed({{(CW-TB){turn_nx[TB-1]}}, turn_nx}) <<< PB;
    raw_ext  = $signed(CW'(raw));
    pos_full = dir_i ? turn_ext - raw_ext : turn_ext + raw_ext;
    pos_nx   = pos_full[mtrk_pkg::POS_W-1:0];

    // alpha * (dp*2^16 - f) / 2^16 split as alpha*dp + floor(-alpha*f / 2^16)
    dp      = $signed(pos_nx - st_i.last_position);
    alpha_s = $signed({1'b0, alpha_i});
    prod_a  = dp * alpha_s;
    prod_b  = st_i.filtered_velocity * alpha_s;
    neg_b   = -((mtrk_pkg::PB_W+1)'(prod_b));
    corr    = neg_b >>> 16;
    vel_sum = SW'(st_i.filtered_velocity) + SW'(prod_a) + SW'(corr);
    if (vel_sum > VelMax) begin
      vel_nx = VW'(VelMax);
    end else if (vel_sum < VelMin) begin
      vel_nx = VW'(VelMin);
    end else begin
      vel_nx = vel_sum[VW-1:0];
    end

    st_o = st_i;
    if (!bad) begin
      case (mtrk_pkg::func_e'(item_i.func))
        mtrk_pkg::FUNC_UPDATE: begin
          st_o.last_raw          = raw;
          st_o.turn_count        = turn_nx;
          st_o.last_position     = pos_nx;
          st_o.filtered_velocity = vel_nx;
        end
        mtrk_pkg::FUNC_POSITION: begin
          st_o.last_raw      = raw;
          st_o.turn_count    = turn_nx;
          st_o.last_position = pos_nx;
        end
        mtrk_pkg::FUNC_RESYNC: begin
          st_o.last_raw = raw;
        end
        mtrk_pkg::FUNC_CLEAR: begin
          st_o.turn_count = '0;
        end
        default: begin
          st_o = st_i;
        end
      endcase
    end

    res_o.status          = bad;
    res_o.position_counts = $signed(st_o.last_position);
    res_o.velocity_q16    = st_o.filtered_velocity;
  end

endmodule

@@ src/multiturn_encoder_position_tracker.sv @@
// top level: multi-turn position tracker with iir velocity filter
// Accepts one raw angle word per clock while the output is not stalled and returns one
// result per word: the word is registered in the input register, the update logic (unwrap,
// position, two 16-bit coefficient multiplies and a saturating add) works on it and writes
// the tracker state and the output register together once the output register is free.
// The state loop through that logic sets the sustained rate of one word per cycle.
// Out-of-range words return status 1 and leave the state untouched. Configuration writes
// are always taken and apply to every word processed after the write.
module multiturn_encoder_position_tracker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mtrk_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mtrk_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_idx_i,
  input  logic [15:0]    cfg_data_i
);

  mtrk_pkg::in_t                in_q;
  logic                         in_vld_q;
  mtrk_pkg::out_t               out_q;
  mtrk_pkg::out_t               out_d;
  logic                         out_vld_q;
  mtrk_pkg::st_t                st_q;
  mtrk_pkg::st_t                st_d;
  logic                         dir_q;
  logic [mtrk_pkg::ALPHA_W-1:0] alpha_q;
  logic                         proc;

  assign proc        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || proc;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  mtrk_update u_update (
    .st_i   (st_q),
    .item_i (in_q),
    .dir_i  (dir_q),
    .alpha_i(alpha_q),
    .st_o   (st_d),
    .res_o  (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
      dir_q     <= 1'b0;
      alpha_q   <= mtrk_pkg::ALPHA_RESET;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (proc) begin
        out_vld_q <= 1'b1;
        st_q      <= st_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (mtrk_pkg::reg_idx_e'(cfg_idx_i))
          mtrk_pkg::REG_DIRECTION: dir_q <= cfg_data_i[0];
          mtrk_pkg::REG_ALPHA:     alpha_q <= cfg_data_i;
          default:                 dir_q <= dir_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (proc) begin
      out_q <= out_d;
    end
  end

  // rejected words leave the tracker state alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && out_d.status |=> st_q == $past(st_q))
    else $error("state changed on a rejected word");

  // the turn counter moves by at most one turn per sample unless cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && (mtrk_pkg::func_e'(in_q.func) != mtrk_pkg::FUNC_CLEAR) |=>
      (st_q.turn_count == $past(st_q.turn_count)) ||
      (st_q.turn_count == $past(st_q.turn_count) + mtrk_pkg::TURN_BITS'(1)) ||
      (st_q.turn_count == $past(st_q.turn_count) - mtrk_pkg::TURN_BITS'(1)))
    else $error("turn counter jumped by more than one");

  // the result shows the position held in the state after the sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_vld_q && (out_q.position_counts == $signed(st_q.last_position)))
    else $error("result position differs from tracker state");

endmodule

@@ bench/tb.sv @@
// self-checking testbench for the multi-turn position tracker with iir velocity filter
module tb;

  localparam int     LIMIT     = 600000;
  localparam int     PHASE_LEN = 275;
  localparam longint FULL      = longint'(1) <<< mtrk_pkg::PRECISION_BITS;
  localparam longint HALF      = longint'(1) <<< (mtrk_pkg::PRECISION_BITS - 1);
  localparam longint VEL_MAX   = (longint'(1) <<< (mtrk_pkg::VEL_W - 1)) - 1;
  localparam longint VEL_MIN   = -(longint'(1) <<< (mtrk_pkg::VEL_W - 1));

  class tracker_model;
    bit                                  dir_neg;
    logic [mtrk_pkg::ALPHA_W-1:0]        alpha;
    logic [mtrk_pkg::PRECISION_BITS-1:0] last_raw;
    logic [mtrk_pkg::TURN_BITS-1:0]      turns;
    logic [mtrk_pkg::POS_W-1:0]          position;
    logic signed [mtrk_pkg::VEL_W-1:0]   velocity;
    mtrk_pkg::out_t                      pending_results[$];
    int                                  errors;
    int                                  n_words;
    int                                  n_rejected;
    int                                  n_results;

    function new();
      dir_neg  = 1'b0;
      alpha    = mtrk_pkg::ALPHA_RESET;
      last_raw = '0;
      turns    = '0;
      position = '0;
      velocity = '0;
    endfunction

    function void write_reg(mtrk_pkg::reg_idx_e idx, logic [15:0] data);
      if (idx == mtrk_pkg::REG_DIRECTION) dir_neg = data[0];
      else alpha = data[mtrk_pkg::ALPHA_W-1:0];
    endfunction

    function void place(logic [mtrk_pkg::PRECISION_BITS-1:0] raw);
      longint d;
      longint sraw;
      longint pos;
      d = longint'(last_raw) - longint'(raw);
      if (d >= HALF || d <= -HALF) begin
        if ((d > 0) ^ dir_neg) turns = turns + 1'b1;
        else turns = turns - 1'b1;
      end
      last_raw = raw;
      sraw = dir_neg ? -longint'(raw) : longint'(raw);
      pos = longint'($signed(turns)) * FULL + sraw;
      position = pos[mtrk_pkg::POS_W-1:0];
    endfunction

    function void take_word(mtrk_pkg::in_t item);
      mtrk_pkg::out_t             e;
      logic [mtrk_pkg::POS_W-1:0] old_pos;
      logic [mtrk_pkg::POS_W-1:0] delta;
      longint                     v;
      longint                     f;
      longint                     nv;
      n_words++;
      e.status = 1'b0;
      if (item.raw_angle >= FULL) begin
        e.status = 1'b1;
        n_rejected++;
      end else begin
        case (mtrk_pkg::func_e'(item.func))
          mtrk_pkg::FUNC_UPDATE: begin
            old_pos = position;
            place(item.raw_angle[mtrk_pkg::PRECISION_BITS-1:0]);
            delta = position - old_pos;
            v = longint'($signed(delta)) * 65536;
            f = longint'(velocity);
            nv = f + (((v - f) * longint'(alpha)) >>> 16);
            if (nv > VEL_MAX) nv = VEL_MAX;
            if (nv < VEL_MIN) nv = VEL_MIN;
            velocity = nv[mtrk_pkg::VEL_W-1:0];
          end
          mtrk_pkg::FUNC_POSITION: place(item.raw_angle[mtrk_pkg::PRECISION_BITS-1:0]);
          mtrk_pkg::FUNC_RESYNC: last_raw = item.raw_angle[mtrk_pkg::PRECISION_BITS-1:0];
          default: turns = '0;
        endcase
      end
      e.position_counts = position;
      e.velocity_q16    = velocity;
      pending_results.push_back(e);
    endfunction

    function void check_result(mtrk_pkg::out_t got);
      mtrk_pkg::out_t e;
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.position_counts !== e.position_counts) begin
        $error("position_counts: expected %0d, got %0d", e.position_counts,
               got.position_counts);
        errors++;
      end
      if (got.velocity_q16 !== e.velocity_q16) begin
        $error("velocity_q16: expected %0d, got %0d", e.velocity_q16, got.velocity_q16);
        errors++;
      end
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid;
  logic           in_ready_o;
  mtrk_pkg::in_t  in_data;
  logic           out_valid_o;
  logic           out_ready;
  mtrk_pkg::out_t out_data_o;
  logic           cfg_valid;
  logic           cfg_ready_o;
  logic           cfg_idx;
  logic [15:0]    cfg_data;

  tracker_model trk;
  int           cycle_count;
  int           reg_writes;
  int           walk_raw;
  int           hold_asks;
  bit           rx_free;

  multiturn_encoder_position_tracker uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (in_valid && in_ready_o) trk.take_word(in_data);
    if (out_valid_o && out_ready) trk.check_result(out_data_o);
  end

  // receiver stall pattern, with long hold-offs on request
  initial begin
    int hold_seen;
    int hold_left;
    int mode;
    int mode_left;
    int tick;
    bit r;
    hold_seen = 0;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = 400;
      end
      if (rx_free) begin
        r = 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        r = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = int'($urandom_range(0, 3));
          mode_left = int'($urandom_range(20, 200));
        end
        mode_left--;
        case (mode)
          0: r = 1'b1;
          1: r = 1'($urandom_range(0, 1));
          2: r = ($urandom_range(0, 3) == 0);
          default: r = (tick % 3 != 0);
        endcase
      end
      out_ready <= r;
    end
  end

  function automatic mtrk_pkg::in_t word(mtrk_pkg::func_e f, logic [15:0] raw);
    mtrk_pkg::in_t w;
    w.func      = f;
    w.raw_angle = raw;
    return w;
  endfunction

  task automatic send_word(mtrk_pkg::in_t w);
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic pause_sender(int n);
    if (n > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    pause_sender(1);
    while (trk.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(mtrk_pkg::reg_idx_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    trk.write_reg(idx, data);
    reg_writes++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic mtrk_pkg::in_t random_word();
    int            pick;
    int            step;
    mtrk_pkg::in_t w;
    pick = int'($urandom_range(0, 99));
    if (pick < 8) begin
      w.func      = 2'($urandom_range(0, 3));
      w.raw_angle = 16'($urandom_range(4096, 65535));
      return w;
    end
    pick = int'($urandom_range(0, 99));
    if (pick < 60) w.func = mtrk_pkg::FUNC_UPDATE;
    else if (pick < 80) w.func = mtrk_pkg::FUNC_POSITION;
    else if (pick < 92) w.func = mtrk_pkg::FUNC_RESYNC;
    else w.func = mtrk_pkg::FUNC_CLEAR;
    pick = int'($urandom_range(0, 99));
    if (pick < 70) step = int'($urandom_range(0, 600)) - 300;
    else if (pick < 85) step = 2048 + int'($urandom_range(0, 4)) - 2;
    else step = int'($urandom_range(0, 4095));
    walk_raw    = (walk_raw + step) & 4095;
    w.raw_angle = 16'(walk_raw);
    return w;
  endfunction

  task automatic send_random(int count);
    int burst;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if (burst == 0) begin
        burst = int'($urandom_range(1, 40));
        if ($urandom_range(0, 3) != 0) pause_sender(int'($urandom_range(1, 10)));
      end
      burst--;
      send_word(random_word());
    end
  endtask

  // resync low then update high: one turn step per pair
  task automatic run_up_turns(int pairs);
    int r;
    for (int k = 0; k < pairs; k++) begin
      r = int'($urandom_range(0, 2047));
      send_word(word(mtrk_pkg::FUNC_RESYNC, 16'(r)));
      send_word(word(mtrk_pkg::FUNC_UPDATE, 16'($urandom_range(r + 2048, 4095))));
    end
  endtask

  initial begin
    logic [15:0] phase_alpha [6];
    bit          phase_dir [6];
    trk         = new();
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_idx     = mtrk_pkg::REG_DIRECTION;
    cfg_data    = '0;
    cycle_count = 0;
    reg_writes  = 0;
    walk_raw    = 0;
    hold_asks   = 0;
    rx_free     = 1'b0;
    phase_dir   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    phase_alpha = '{16'd46884, 16'hFFFF, 16'd0, 16'($urandom), 16'd1, 16'd46884};
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: unwrap edges, rejected words, every function
    send_word(word(mtrk_pkg::FUNC_UPDATE, 16'd0));
    send_word(word(mtrk_pkg::FUNC_UPDATE, 16'd4095));
    send_word(word(mtrk_pkg::FUNC_UPDATE, 16'd2048));
    send_word(word(mtrk_pkg::FUNC_UPDATE, 16'd0));
    send_word(word(mtrk_pkg::FUNC_UPDATE, 16'd2047));
    send_word(word(mtrk_pkg::FUNC_UPDATE, 16'd4096));
    send_word(word(mtrk_pkg::FUNC_POSITION, 16'hFFFF));
    send_word(word(mtrk_pkg::FUNC_RESYNC, 16'h8000));
    send_word(word(mtrk_pkg::FUNC_CLEAR, 16'h1000));
    send_word(word(mtrk_pkg::FUNC_POSITION, 16'd100));
    send_word(word(mtrk_pkg::FUNC_RESYNC, 16'd4000));
    send_word(word(mtrk_pkg::FUNC_POSITION, 16'd10));
    send_word(word(mtrk_pkg::FUNC_CLEAR, 16'd5));
    send_word(word(mtrk_pkg::FUNC_UPDATE, 16'd5));
    send_word(word(mtrk_pkg::FUNC_UPDATE, 16'd4095));
    drain();

    // reversed direction, full filter gain, a long run of whole turns
    write_reg(mtrk_pkg::REG_DIRECTION, 16'd1);
    write_reg(mtrk_pkg::REG_ALPHA, 16'hFFFF);
    rx_free = 1'b1;
    run_up_turns(40);
    send_word(word(mtrk_pkg::FUNC_UPDATE, 16'd4095));
    send_word(word(mtrk_pkg::FUNC_CLEAR, 16'd0));
    send_word(word(mtrk_pkg::FUNC_UPDATE, 16'd0));
    send_word(word(mtrk_pkg::FUNC_UPDATE, 16'd2048));
    send_word(word(mtrk_pkg::FUNC_POSITION, 16'd1));
    drain();
    write_reg(mtrk_pkg::REG_ALPHA, 16'd0);
    send_word(word(mtrk_pkg::FUNC_UPDATE, 16'd3000));
    send_word(word(mtrk_pkg::FUNC_UPDATE, 16'd100));
    drain();
    rx_free = 1'b0;

    for (int p = 0; p < 6; p++) begin
      write_reg(mtrk_pkg::REG_DIRECTION, 16'(phase_dir[p]));
      write_reg(mtrk_pkg::REG_ALPHA, phase_alpha[p]);
      if (p == 0) hold_asks++;
      send_random(PHASE_LEN);
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("covered %0d words (%0d rejected), %0d results, %0d register writes",
             trk.n_words, trk.n_rejected, trk.n_results, reg_writes);
    $display("both directions, filter gain extremes, long turn runs and output stalls");
    if (trk.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
